FILE: src/ssd_pkg.sv
// Shared types, codes and the word compare function for the string sorter.
package ssd_pkg;

   localparam int NUM_STRINGS_DEF      = 16;
   localparam int WORDS_PER_STRING_DEF = 8;

   // Request command codes
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_SORT  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Write data source select
   localparam logic [1:0] WSRC_ZERO = 2'd0;
   localparam logic [1:0] WSRC_REQ  = 2'd1;
   localparam logic [1:0] WSRC_RD_A = 2'd2;
   localparam logic [1:0] WSRC_RD_B = 2'd3;

   typedef struct packed {
      logic       wr_en;
      logic [1:0] wr_src;
      logic       rd_en;
      logic       rsp_load;
      logic       rsp_use_read;
      logic       rsp_accepted;
   } ctl_cmd_type;

   typedef struct packed {
      logic decided;
      logic less;
   } ctl_sts_type;

   // Compare one word of two strings, first character in the top byte.
   // Decided when a byte differs or the first string ends in this word.
   function automatic ctl_sts_type cmp_word(input logic [63:0] x, input logic [63:0] y);
      ctl_sts_type r;
      logic [7:0]  xb;
      logic [7:0]  yb;
      r.decided = 1'b0;
      r.less    = 1'b0;
      for (int k = 0; k < 8; k++) begin
         xb = x[63-8*k -: 8];
         yb = y[63-8*k -: 8];
         if (!r.decided) begin
            if (xb != yb) begin
               r.decided = 1'b1;
               r.less    = (xb < yb);
            end else if (xb == 8'd0) begin
               r.decided = 1'b1;
            end
         end
      end
      return r;
   endfunction

endpackage

FILE: src/ssd_datapath.sv
// String store memory, read registers, word comparator and response register.
module ssd_datapath #(
   parameter int Depth = 128,
   parameter int AW    = 7
) (
   input  logic                clock,
   input  ssd_pkg::ctl_cmd_type cmd,
   input  logic [AW-1:0]       wr_addr,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   input  logic [63:0]         write_word,
   output ssd_pkg::ctl_sts_type sts,
   output logic [63:0]         rsp_read_word,
   output logic                rsp_accepted
);
   import ssd_pkg::*;

   logic [63:0] store_mem [Depth];
   logic [63:0] rd_a_ff;
   logic [63:0] rd_b_ff;
   logic [63:0] wr_data;
   logic [63:0] rsp_word_ff;
   logic [63:0] rsp_word_in;
   logic        rsp_acc_ff;
   logic        rsp_acc_in;

   // write data select
   always_comb begin
      unique case (cmd.wr_src)
         WSRC_ZERO: wr_data = '0;
         WSRC_REQ:  wr_data = write_word;
         WSRC_RD_A: wr_data = rd_a_ff;
         WSRC_RD_B: wr_data = rd_b_ff;
         default:   wr_data = '0;
      endcase
   end

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= store_mem[rd_addr_a];
         rd_b_ff <= store_mem[rd_addr_b];
      end
   end

   assign sts = cmp_word(rd_a_ff, rd_b_ff);

   // response word register
   always_comb begin
      rsp_word_in = rsp_word_ff;
      rsp_acc_in  = rsp_acc_ff;
      if (cmd.rsp_load) begin
         rsp_word_in = cmd.rsp_use_read ? rd_a_ff : 64'd0;
         rsp_acc_in  = cmd.rsp_accepted;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign rsp_read_word = rsp_word_ff;
   assign rsp_accepted  = rsp_acc_ff;

endmodule

FILE: src/ssd_ctrl.sv
// Controller: clearing pass, command handling and the exchange sort sequencer.
module ssd_ctrl #(
   parameter int NumStrings     = 16,
   parameter int WordsPerString = 8,
   parameter int AW             = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [3:0]           req_string_slot,
   input  logic [2:0]           req_word_slot,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssd_pkg::ctl_cmd_type cmd,
   output logic [AW-1:0]        wr_addr,
   output logic [AW-1:0]        rd_addr_a,
   output logic [AW-1:0]        rd_addr_b,
   input  ssd_pkg::ctl_sts_type sts
);
   import ssd_pkg::*;

   localparam int Depth = NumStrings * WordsPerString;
   localparam int IW    = $clog2(NumStrings);
   localparam int WW    = (WordsPerString > 1) ? $clog2(WordsPerString) : 1;

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_RD_WAIT = 4'd2;
   localparam logic [3:0] ST_S_READ  = 4'd3;
   localparam logic [3:0] ST_S_CMP   = 4'd4;
   localparam logic [3:0] ST_W_READ  = 4'd5;
   localparam logic [3:0] ST_W_WA    = 4'd6;
   localparam logic [3:0] ST_W_WB    = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [IW-1:0] oi_ff, oi_in;
   logic [IW-1:0] ii_ff, ii_in;
   logic [WW-1:0] w_ff, w_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          accept;
   logic          in_range;
   logic [AW-1:0] req_addr;
   logic [AW-1:0] pair_a;
   logic [AW-1:0] pair_b;
   logic          last_word;
   logic          last_inner;
   logic          last_outer;

   assign in_range = (32'(req_string_slot) < NumStrings)
                  && (32'(req_word_slot) < WordsPerString);
   assign req_addr = AW'(req_string_slot) * AW'(WordsPerString) + AW'(req_word_slot);
   assign pair_a   = AW'(oi_ff) * AW'(WordsPerString) + AW'(w_ff);
   assign pair_b   = AW'(ii_ff) * AW'(WordsPerString) + AW'(w_ff);

   assign last_word  = (32'(w_ff) == WordsPerString - 1);
   assign last_inner = (32'(ii_ff) == NumStrings - 1);
   assign last_outer = (32'(oi_ff) == NumStrings - 2);

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign rd_addr_a = (state_ff == ST_IDLE) ? req_addr : pair_a;
   assign rd_addr_b = pair_b;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      oi_in    = oi_ff;
      ii_in    = ii_ff;
      w_in     = w_ff;
      cmd      = '0;
      wr_addr  = pair_a;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_ZERO;
            wr_addr    = clr_ff;
            clr_in     = clr_ff + AW'(1);
            if (32'(clr_ff) == Depth - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            wr_addr = req_addr;
            if (accept) begin
               unique case (req_command)
                  CMD_WRITE: begin
                     cmd.wr_en        = in_range;
                     cmd.wr_src       = WSRC_REQ;
                     cmd.rsp_load     = 1'b1;
                     cmd.rsp_accepted = in_range;
                  end
                  CMD_SORT: begin
                     oi_in    = '0;
                     ii_in    = IW'(1);
                     w_in     = '0;
                     state_in = ST_S_READ;
                  end
                  CMD_READ: begin
                     if (in_range) begin
                        cmd.rd_en = 1'b1;
                        state_in  = ST_RD_WAIT;
                     end else begin
                        cmd.rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_use_read = 1'b1;
            cmd.rsp_accepted = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_S_CMP;
         end
         ST_W_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_W_WA;
         end
         ST_W_WA: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_RD_B;
            wr_addr    = pair_a;
            state_in   = ST_W_WB;
         end
         ST_S_CMP, ST_W_WB: begin
            if (state_ff == ST_W_WB) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = WSRC_RD_A;
               wr_addr    = pair_b;
            end
            if (state_ff == ST_S_CMP && sts.decided && sts.less) begin
               // string a orders below b: exchange all words
               w_in     = '0;
               state_in = ST_W_READ;
            end else if (state_ff == ST_S_CMP && !sts.decided && !last_word) begin
               w_in     = w_ff + WW'(1);
               state_in = ST_S_READ;
            end else if (state_ff == ST_W_WB && !last_word) begin
               w_in     = w_ff + WW'(1);
               state_in = ST_W_READ;
            end else begin
               // pair finished: advance to the next pair or finish
               w_in = '0;
               if (!last_inner) begin
                  ii_in    = ii_ff + IW'(1);
                  state_in = ST_S_READ;
               end else if (!last_outer) begin
                  oi_in    = oi_ff + IW'(1);
                  ii_in    = oi_ff + IW'(2);
                  state_in = ST_S_READ;
               end else begin
                  oi_in            = '0;
                  ii_in            = '0;
                  cmd.rsp_load     = 1'b1;
                  cmd.rsp_accepted = 1'b1;
                  state_in         = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid holds while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         oi_ff        <= '0;
         ii_ff        <= '0;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         oi_ff        <= oi_in;
         ii_ff        <= ii_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/string_sort_descending.sv
// Top level of the descending string sorter: controller plus datapath.
// The store holds NUM_STRINGS strings of WORDS_PER_STRING 64-bit words,
// first character in the top byte. After reset a clearing pass zeroes the
// store (128 words by default), one word per cycle, with req_stall high. A
// write is answered from the request directly; a read registers the word
// first. A sort visits every pair i<j: it reads and compares the strings
// word by word until they differ or end, and a swap reads each word pair
// and writes the two words back one after the other, since the store has
// one write port. Every command returns exactly one response word.
module string_sort_descending #(
   parameter int NumStrings     = ssd_pkg::NUM_STRINGS_DEF,
   parameter int WordsPerString = ssd_pkg::WORDS_PER_STRING_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_string_slot,
   input  logic [2:0]  req_word_slot,
   input  logic [63:0] req_write_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_read_word,
   output logic        rsp_accepted
);
   import ssd_pkg::*;

   localparam int Depth = NumStrings * WordsPerString;
   localparam int AW    = $clog2(Depth);

   ctl_cmd_type   cmd;
   ctl_sts_type   sts;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;

   ssd_ctrl #(
      .NumStrings    (NumStrings),
      .WordsPerString(WordsPerString),
      .AW            (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_string_slot(req_string_slot),
      .req_word_slot  (req_word_slot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_addr_a      (rd_addr_a),
      .rd_addr_b      (rd_addr_b),
      .sts            (sts)
   );

   ssd_datapath #(
      .Depth(Depth),
      .AW   (AW)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .write_word   (req_write_word),
      .sts          (sts),
      .rsp_read_word(rsp_read_word),
      .rsp_accepted (rsp_accepted)
   );

endmodule

FILE: src/ssd_checker.sv
// Port-level checks for the string sorter, bound to the top level.
module ssd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_read_word,
   input logic        rsp_accepted
);
   import ssd_pkg::*;

   // a response not taken stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response word does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_read_word))
      else $error("response word changed while stalled");

   // a rejected command returns a zero word
   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_read_word == 64'd0)
      else $error("rejected command returned data");

   // a write answers in the next cycle
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_WRITE |=> rsp_valid)
      else $error("write produced no response");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind string_sort_descending ssd_checker u_ssd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_command  (req_command),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_read_word(rsp_read_word),
   .rsp_accepted (rsp_accepted)
);
